@@ rtl/core/rrss_pkg.sv @@
// ============================================================================
// Round-robin slice scheduler package
// Shared widths, codes, state encoding and the result record of the
// round-robin slice scheduler.
// ============================================================================
package rrss_pkg;

    // Default size of the job table.
    localparam int unsigned MAX_JOBS_DEFAULT = 16;

    // Field widths fixed by the interface.
    localparam int unsigned ARR_W      = 16;
    localparam int unsigned QUANTUM_W  = 16;
    localparam int unsigned TIME_W     = 21;
    localparam int unsigned TOTAL_W    = 25;
    localparam int unsigned SLOT_OUT_W = 4;
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 136;

    // Slice quantum after reset.
    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd10;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD     = 2'd0,
        CMD_DISPATCH = 2'd1,
        CMD_CLEAR    = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STAT_LOADED  = 3'd0,
        STAT_FULL    = 3'd1,
        STAT_SLICE   = 3'd2,
        STAT_NONE    = 3'd3,
        STAT_CLEARED = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CYC,
        S_EARLY,
        S_BASE,
        S_ADV,
        S_TURN,
        S_WAIT,
        S_TOTAL,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status               status;
        logic [SLOT_OUT_W-1:0] job_slot;
        logic [ARR_W-1:0]      slice_length;
        logic [TIME_W-1:0]     finish_time;
        logic                  job_finished;
        logic [TIME_W-1:0]     waiting_time;
        logic [TIME_W-1:0]     turnaround_time;
        logic [TOTAL_W-1:0]    sum_waiting;
        logic [TOTAL_W-1:0]    sum_turnaround;
        logic                  all_done;
    } t_result;

endpackage

@@ rtl/core/round_robin_slice_scheduler_top.sv @@
// ============================================================================
// Round-robin slice scheduler
// Holds a table of jobs and, on each dispatch request, runs one time slice
// of the next job in round-robin order, reporting per-job and total waiting
// and turnaround times.
// ============================================================================
//
// Channel     Direction  Handshake                   Contents
// s_axis      in         i_s_axis_tvalid/o_s_axis_tready  command, arrival, burst
// m_axis      out        o_m_axis_tvalid/i_m_axis_tready  status and slice report
// cfg         in         i_cfg_valid/o_cfg_ready      slice quantum
//
// A load or a clear goes to the done state, and its result enters the output
// register once the previous result has been taken; the next request is taken
// after that. The unused command is accepted and dropped without a result. A
// dispatch on an empty table goes straight to the done state; otherwise the
// job is chosen by a scan of the table that reads one entry per cycle from the
// job memory, first in cyclic order and, when that finds nothing, again for
// the earliest arrival; two arithmetic steps follow, and three more when the
// job completes. The reset is synchronous and active low; it empties the
// table and sets the quantum to ten, and the memories themselves are not
// cleared. A request is accepted only while the scheduler is idle; a finished
// result stalls the scheduler until the previous result has been taken.
// ============================================================================
module round_robin_slice_scheduler_top #(
    parameter int unsigned MAX_JOBS = rrss_pkg::MAX_JOBS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request channel.
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata: arrival_time [15:0], burst_length [31:16].
    input  logic [rrss_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: command [1:0].
    input  logic [rrss_pkg::CMD_W-1:0]      i_s_axis_tuser,
    // Result channel.
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tdata: job_slot [3:0], slice_length [19:4], finish_time [40:20],
    // job_finished [41], waiting_time [62:42], turnaround_time [83:63],
    // sum_waiting [108:84], sum_turnaround [133:109], all_done [134],
    // zero padding [135].
    output logic [rrss_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // tuser: status [2:0].
    output logic [rrss_pkg::STATUS_W-1:0]   o_m_axis_tuser,
    // Configuration channel: slice quantum.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rrss_pkg::QUANTUM_W-1:0]  i_cfg_data
);

    // Slot index width and job count width follow from the table size.
    localparam int unsigned SW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int unsigned CW = $clog2(MAX_JOBS + 1);
    localparam int unsigned AW = rrss_pkg::ARR_W;
    localparam int unsigned TW = rrss_pkg::TIME_W;
    localparam int unsigned SUMW = rrss_pkg::TOTAL_W;

    // Job memories: one write and one registered read per cycle each.
    logic [AW-1:0] r_arr_mem [MAX_JOBS];
    logic [AW-1:0] r_bur_mem [MAX_JOBS];
    logic [AW-1:0] r_rem_mem [MAX_JOBS];

    rrss_pkg::t_state  r_state, n_state;
    rrss_pkg::t_result r_out;
    logic              r_out_vld;

    // Scheduler state.
    logic [AW-1:0]   r_quantum;
    logic [CW-1:0]   r_job_count;
    logic [CW-1:0]   r_fin_count;
    logic [TW-1:0]   r_clock;
    logic [SW-1:0]   r_cur_slot;
    logic            r_started;
    logic [SUMW-1:0] r_total_wait;
    logic [SUMW-1:0] r_total_turn;

    // Table scan pipeline.
    logic [SW-1:0] r_scan_slot;
    logic [CW-1:0] r_left;
    logic          r_q_vld;
    logic [SW-1:0] r_q_slot;
    logic [AW-1:0] r_arr_q;
    logic [AW-1:0] r_bur_q;
    logic [AW-1:0] r_rem_q;

    // Selected job and working values.
    logic            r_found;
    logic [SW-1:0]   r_sel_slot;
    logic [AW-1:0]   r_sel_arr;
    logic [AW-1:0]   r_sel_bur;
    logic [AW-1:0]   r_sel_rem;
    logic [AW-1:0]   r_run;
    logic [TW-1:0]   r_base;
    logic [TW-1:0]   r_turn;
    logic [TW-1:0]   r_wait;
    logic            r_finished;
    rrss_pkg::t_status r_status;
    logic [SW-1:0]   r_res_slot;

    // Decoded request.
    rrss_pkg::t_cmd in_cmd;
    logic [AW-1:0]  in_arr;
    logic [AW-1:0]  in_bur;
    logic           in_acc;
    logic           table_full;

    // Scan and arithmetic terms.
    logic           scan_last;
    logic           cyc_hit;
    logic           early_take;
    logic           issue;
    logic [SW-1:0]  scan_next;
    logic [AW-1:0]  q_eff;
    logic [AW-1:0]  rem_new;
    logic [TW:0]    clk_sum;
    logic [SUMW:0]  wait_sum;
    logic [SUMW:0]  turn_sum;
    logic           out_free;

    // Memory write controls.
    logic           load_we;
    logic           rem_we;
    logic [SW-1:0]  rem_wa;
    logic [AW-1:0]  rem_wd;

    assign in_cmd     = rrss_pkg::t_cmd'(i_s_axis_tuser);
    assign in_arr     = i_s_axis_tdata[AW-1:0];
    assign in_bur     = (i_s_axis_tdata[2*AW-1:AW] == '0) ? AW'(1)
                                                          : i_s_axis_tdata[2*AW-1:AW];
    assign in_acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign table_full = (r_job_count >= CW'(MAX_JOBS));

    // The slot after the given one in cyclic order over the loaded jobs.
    assign scan_next  = ((CW'(r_scan_slot) + 1'b1) == r_job_count) ? '0
                                                                   : r_scan_slot + 1'b1;

    assign scan_last  = r_q_vld && (r_left == '0);
    assign cyc_hit    = r_q_vld && (r_rem_q != '0) && (TW'(r_arr_q) <= r_clock);
    assign early_take = r_q_vld && (r_rem_q != '0) && (!r_found || (r_arr_q < r_sel_arr));

    assign q_eff      = (r_quantum == '0) ? AW'(1) : r_quantum;
    assign rem_new    = r_sel_rem - r_run;
    assign clk_sum    = {1'b0, r_base} + (TW + 1)'(r_run);
    assign wait_sum   = {1'b0, r_total_wait} + (SUMW + 1)'(r_wait);
    assign turn_sum   = {1'b0, r_total_turn} + (SUMW + 1)'(r_turn);
    assign out_free   = !r_out_vld || i_m_axis_tready;

    // ------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            rrss_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (in_cmd)
                        rrss_pkg::CMD_LOAD:  n_state = rrss_pkg::S_DONE;
                        rrss_pkg::CMD_CLEAR: n_state = rrss_pkg::S_DONE;
                        rrss_pkg::CMD_DISPATCH: begin
                            if (r_job_count == '0) begin
                                n_state = rrss_pkg::S_DONE;
                            end else if (r_started) begin
                                n_state = rrss_pkg::S_CYC;
                            end else begin
                                n_state = rrss_pkg::S_EARLY;
                            end
                        end
                        default: n_state = rrss_pkg::S_IDLE;
                    endcase
                end
            end
            rrss_pkg::S_CYC: begin
                if (cyc_hit) begin
                    n_state = rrss_pkg::S_BASE;
                end else if (scan_last) begin
                    n_state = rrss_pkg::S_EARLY;
                end
            end
            rrss_pkg::S_EARLY: begin
                if (scan_last) begin
                    n_state = (r_found || early_take) ? rrss_pkg::S_BASE : rrss_pkg::S_DONE;
                end
            end
            rrss_pkg::S_BASE:  n_state = rrss_pkg::S_ADV;
            rrss_pkg::S_ADV:   n_state = (rem_new == '0) ? rrss_pkg::S_TURN : rrss_pkg::S_DONE;
            rrss_pkg::S_TURN:  n_state = rrss_pkg::S_WAIT;
            rrss_pkg::S_WAIT:  n_state = rrss_pkg::S_TOTAL;
            rrss_pkg::S_TOTAL: n_state = rrss_pkg::S_DONE;
            rrss_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = rrss_pkg::S_IDLE;
                end
            end
            default: n_state = rrss_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Control outputs.
    // ------------------------------------------------------------------
    always_comb begin
        o_s_axis_tready = (r_state == rrss_pkg::S_IDLE);
        issue   = 1'b0;
        load_we = 1'b0;
        rem_we  = 1'b0;
        rem_wa  = r_sel_slot;
        rem_wd  = rem_new;
        case (r_state)
            rrss_pkg::S_IDLE: begin
                if (in_acc && (in_cmd == rrss_pkg::CMD_LOAD) && !table_full) begin
                    load_we = 1'b1;
                    rem_we  = 1'b1;
                    rem_wa  = r_job_count[SW-1:0];
                    rem_wd  = in_bur;
                end
            end
            rrss_pkg::S_CYC: begin
                issue = (r_left != '0) && !cyc_hit;
            end
            rrss_pkg::S_EARLY: begin
                issue = (r_left != '0);
            end
            rrss_pkg::S_ADV: begin
                rem_we = 1'b1;
            end
            default: begin
                issue = 1'b0;
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Job memories.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_arr_mem[r_job_count[SW-1:0]] <= in_arr;
            r_bur_mem[r_job_count[SW-1:0]] <= in_bur;
        end
        if (rem_we) begin
            r_rem_mem[rem_wa] <= rem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_arr_q  <= r_arr_mem[r_scan_slot];
        r_bur_q  <= r_bur_mem[r_scan_slot];
        r_rem_q  <= r_rem_mem[r_scan_slot];
        r_q_slot <= r_scan_slot;
    end

    // ------------------------------------------------------------------
    // Scheduler registers and datapath.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rrss_pkg::S_IDLE;
            r_out_vld    <= 1'b0;
            r_quantum    <= rrss_pkg::QUANTUM_RESET;
            r_job_count  <= '0;
            r_fin_count  <= '0;
            r_clock      <= '0;
            r_cur_slot   <= '0;
            r_started    <= 1'b0;
            r_total_wait <= '0;
            r_total_turn <= '0;
            r_scan_slot  <= '0;
            r_left       <= '0;
            r_q_vld      <= 1'b0;
            r_found      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_q_vld <= issue;

            if (i_cfg_valid && o_cfg_ready) begin
                r_quantum <= i_cfg_data;
            end

            if (issue) begin
                r_scan_slot <= scan_next;
                r_left      <= r_left - 1'b1;
            end

            // A new result replaces the one just taken in the same cycle.
            if ((r_state == rrss_pkg::S_DONE) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                rrss_pkg::S_IDLE: begin
                    r_run      <= '0;
                    r_finished <= 1'b0;
                    r_wait     <= '0;
                    r_turn     <= '0;
                    r_res_slot <= load_we ? r_job_count[SW-1:0] : '0;
                    if (in_acc) begin
                        case (in_cmd)
                            rrss_pkg::CMD_LOAD: begin
                                if (table_full) begin
                                    r_status <= rrss_pkg::STAT_FULL;
                                end else begin
                                    r_status    <= rrss_pkg::STAT_LOADED;
                                    r_job_count <= r_job_count + 1'b1;
                                end
                            end
                            rrss_pkg::CMD_CLEAR: begin
                                r_status     <= rrss_pkg::STAT_CLEARED;
                                r_job_count  <= '0;
                                r_fin_count  <= '0;
                                r_clock      <= '0;
                                r_cur_slot   <= '0;
                                r_started    <= 1'b0;
                                r_total_wait <= '0;
                                r_total_turn <= '0;
                            end
                            rrss_pkg::CMD_DISPATCH: begin
                                // Stays "nothing left" unless a slice is run.
                                r_status <= rrss_pkg::STAT_NONE;
                                r_left   <= r_job_count;
                                r_found  <= 1'b0;
                                if (r_started) begin
                                    r_scan_slot <= ((CW'(r_cur_slot) + 1'b1) == r_job_count)
                                                   ? '0 : r_cur_slot + 1'b1;
                                end else begin
                                    r_scan_slot <= '0;
                                end
                            end
                            default: begin
                                r_status <= rrss_pkg::STAT_NONE;
                            end
                        endcase
                    end
                end
                rrss_pkg::S_CYC: begin
                    if (cyc_hit) begin
                        r_sel_slot <= r_q_slot;
                        r_sel_arr  <= r_arr_q;
                        r_sel_bur  <= r_bur_q;
                        r_sel_rem  <= r_rem_q;
                    end else if (scan_last) begin
                        // Nothing ready in cyclic order: fall back to the
                        // earliest arrival over the whole table.
                        r_scan_slot <= '0;
                        r_left      <= r_job_count;
                        r_found     <= 1'b0;
                    end
                end
                rrss_pkg::S_EARLY: begin
                    if (early_take) begin
                        r_found    <= 1'b1;
                        r_sel_slot <= r_q_slot;
                        r_sel_arr  <= r_arr_q;
                        r_sel_bur  <= r_bur_q;
                        r_sel_rem  <= r_rem_q;
                    end
                end
                rrss_pkg::S_BASE: begin
                    r_run  <= (r_sel_rem < q_eff) ? r_sel_rem : q_eff;
                    // An idle clock jumps forward to the job's arrival.
                    r_base <= (r_clock < TW'(r_sel_arr)) ? TW'(r_sel_arr) : r_clock;
                end
                rrss_pkg::S_ADV: begin
                    r_clock    <= clk_sum[TW] ? '1 : clk_sum[TW-1:0];
                    r_sel_rem  <= rem_new;
                    r_cur_slot <= r_sel_slot;
                    r_started  <= 1'b1;
                    r_status   <= rrss_pkg::STAT_SLICE;
                    r_res_slot <= r_sel_slot;
                end
                rrss_pkg::S_TURN: begin
                    r_turn <= r_clock - TW'(r_sel_arr);
                end
                rrss_pkg::S_WAIT: begin
                    r_wait      <= (r_turn > TW'(r_sel_bur)) ? r_turn - TW'(r_sel_bur) : '0;
                    r_finished  <= 1'b1;
                    r_fin_count <= r_fin_count + 1'b1;
                end
                rrss_pkg::S_TOTAL: begin
                    r_total_wait <= wait_sum[SUMW] ? '1 : wait_sum[SUMW-1:0];
                    r_total_turn <= turn_sum[SUMW] ? '1 : turn_sum[SUMW-1:0];
                end
                default: begin
                    r_found <= r_found;
                end
            endcase
        end
    end

    // Result register: payload only, qualified by r_out_vld.
    always_ff @(posedge i_clk) begin
        if ((r_state == rrss_pkg::S_DONE) && out_free) begin
            r_out.status          <= r_status;
            r_out.job_slot        <= rrss_pkg::SLOT_OUT_W'(r_res_slot);
            r_out.slice_length    <= r_run;
            r_out.finish_time     <= r_clock;
            r_out.job_finished    <= r_finished;
            r_out.waiting_time    <= r_wait;
            r_out.turnaround_time <= r_turn;
            r_out.sum_waiting     <= r_total_wait;
            r_out.sum_turnaround  <= r_total_turn;
            r_out.all_done        <= (r_fin_count == r_job_count);
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tdata  = {1'b0, r_out.all_done, r_out.sum_turnaround, r_out.sum_waiting,
                              r_out.turnaround_time, r_out.waiting_time, r_out.job_finished,
                              r_out.finish_time, r_out.slice_length, r_out.job_slot};

`ifndef ASSERT_OFF
    // The table never holds more jobs than it has slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_count <= CW'(MAX_JOBS))
        else $error("job count beyond table size");

    // Finished jobs never outnumber loaded jobs.
    a_fin_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_count <= r_job_count)
        else $error("finished count exceeds job count");

    // The job served last always lies inside the loaded part of the table.
    a_cur_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> (CW'(r_cur_slot) < r_job_count))
        else $error("current slot outside loaded jobs");

    // A completion step counts exactly one finished job.
    a_fin_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrss_pkg::S_WAIT) |=> (r_fin_count == $past(r_fin_count) + 1'b1))
        else $error("finished count not advanced on completion");

    // Requests are taken only when no scan or arithmetic is in progress.
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != rrss_pkg::S_IDLE) |-> !o_s_axis_tready)
        else $error("request accepted while busy");
`endif

endmodule

@@ tb/testbench.sv @@
// ============================================================================
// Round-robin slice scheduler testbench
// Drives load, dispatch, clear and unused requests into the scheduler under
// several slice quanta, predicts every report and checks it field by field.
// ============================================================================
//
// The request side is driven from a queue of pending requests that the main
// initial block fills one phase at a time. A clocked driver offers them with
// random gaps, and a clocked monitor takes the reports with random stalls
// and compares each one with the oldest prediction. The prediction is made
// at the moment a request is accepted, so the scheduler state held here
// always matches the state the block should have after that request.
//
// The quantum register is only written while the scheduler is idle: every
// phase drains all reports and then lets the longest dispatch time pass,
// because an unused command produces no report and may still be in flight.
// ============================================================================
module testbench;

    // Table size used for the instance and for the prediction.
    localparam int unsigned JOB_SLOTS      = rrss_pkg::MAX_JOBS_DEFAULT;
    // Command code that the block ignores; it has no member in the package.
    localparam logic [rrss_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    // Clock and totals saturate at the top of their fields.
    localparam int unsigned NOW_CEILING    = (1 << rrss_pkg::TIME_W) - 1;
    localparam int unsigned TOTAL_CEILING  = (1 << rrss_pkg::TOTAL_W) - 1;
    // Wait after a drain that outlasts the longest dispatch, with margin.
    localparam int unsigned SETTLE_CYCLES  = 2 * JOB_SLOTS + 16;
    // Length of the one long hold-off of the report side.
    localparam int unsigned LONG_HOLD      = 400;
    // Cycles without any handshake before the run is abandoned.
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    // Requests per random phase.
    localparam int unsigned PHASE_REQUESTS = 120;
    // Mismatch lines printed before further ones are only counted.
    localparam int unsigned PRINT_LIMIT    = 50;

    // One request as the sender sees it.
    typedef struct packed {
        logic [rrss_pkg::CMD_W-1:0] cmd;
        logic [rrss_pkg::ARR_W-1:0] arrival;
        logic [rrss_pkg::ARR_W-1:0] burst;
    } t_request;

    // ------------------------------------------------------------------------
    // Block ports. Every input has a known value from time zero.
    // ------------------------------------------------------------------------
    logic                             i_clk           = 1'b0;
    logic                             i_rst_n         = 1'b0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    // tdata: arrival_time [15:0], burst_length [31:16].
    logic [rrss_pkg::IN_DATA_W-1:0]   i_s_axis_tdata  = '0;
    // tuser: command [1:0].
    logic [rrss_pkg::CMD_W-1:0]       i_s_axis_tuser  = '0;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    // tdata: job_slot [3:0], slice_length [19:4], finish_time [40:20],
    // job_finished [41], waiting_time [62:42], turnaround_time [83:63],
    // sum_waiting [108:84], sum_turnaround [133:109], all_done [134],
    // padding [135].
    logic [rrss_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata;
    // tuser: status [2:0].
    logic [rrss_pkg::STATUS_W-1:0]    o_m_axis_tuser;
    logic                             i_cfg_valid     = 1'b0;
    logic                             o_cfg_ready;
    logic [rrss_pkg::QUANTUM_W-1:0]   i_cfg_data      = '0;

    // ------------------------------------------------------------------------
    // Queues and run bookkeeping.
    // ------------------------------------------------------------------------
    t_request          request_queue[$];   // requests waiting to be offered
    rrss_pkg::t_result report_queue[$];    // predicted reports, oldest first
    t_request          offered_request;    // request currently held on the bus

    int unsigned planned_requests  = 0;
    int unsigned accepted_requests = 0;
    int unsigned reports_checked   = 0;
    int unsigned quantum_writes    = 0;
    int unsigned fail_count        = 0;
    int unsigned quiet_cycles      = 0;

    // Idling control of the two sides.
    int unsigned send_gap   = 0;
    bit          send_quiet = 1'b0;
    int unsigned recv_hold  = 0;
    bit          recv_quiet = 1'b0;
    bit          long_hold_wanted = 1'b0;
    bit          long_hold_taken  = 1'b0;

    // ------------------------------------------------------------------------
    // Predicted scheduler state.
    // ------------------------------------------------------------------------
    logic [rrss_pkg::ARR_W-1:0] job_arrival [JOB_SLOTS];
    logic [rrss_pkg::ARR_W-1:0] job_burst   [JOB_SLOTS];
    logic [rrss_pkg::ARR_W-1:0] job_left    [JOB_SLOTS];
    int unsigned      n_jobs       = 0;
    int unsigned      n_done       = 0;
    int unsigned      clock_value  = 0;
    int unsigned      last_served  = 0;
    bit               dispatching  = 1'b0;
    int unsigned      wait_total   = 0;
    int unsigned      turn_total   = 0;
    int unsigned      quantum_setting = 32'(rrss_pkg::QUANTUM_RESET);
    // Coverage counts for the closing summary.
    int unsigned      slices_run   = 0;
    int unsigned      jobs_completed = 0;
    int unsigned      full_rejects = 0;
    int unsigned      idle_jumps   = 0;
    int unsigned      empty_dispatches = 0;

    // ------------------------------------------------------------------------
    // Device under test.
    // ------------------------------------------------------------------------
    round_robin_slice_scheduler_top #(
        .MAX_JOBS (JOB_SLOTS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // Clock with a period of four time units.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Length of an idle stretch: mostly none or short, now and then long.
    function automatic int unsigned idle_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(25, 60);
    endfunction

    // Random content for a field that the command does not use.
    function automatic logic [rrss_pkg::ARR_W-1:0] any_field();
        return rrss_pkg::ARR_W'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // Prediction: applies one accepted request to the scheduler state held
    // here and queues the report it should produce. The unused command
    // changes nothing and produces no report.
    // ------------------------------------------------------------------------
    task automatic schedule_request(input t_request req);
        rrss_pkg::t_result rep;
        int          sel;
        int unsigned step;
        int unsigned run;
        int unsigned turn;
        int unsigned queued_for;
        int unsigned slot;
        logic [rrss_pkg::ARR_W-1:0] burst;
        rep = '0;
        if (req.cmd == CMD_UNUSED) begin
            return;
        end
        if (req.cmd == rrss_pkg::CMD_LOAD) begin
            if (n_jobs >= JOB_SLOTS) begin
                rep.status = rrss_pkg::STAT_FULL;
                full_rejects++;
            end else begin
                // A zero burst is stored as one time unit.
                burst = (req.burst == '0) ? rrss_pkg::ARR_W'(1) : req.burst;
                job_arrival[n_jobs] = req.arrival;
                job_burst[n_jobs]   = burst;
                job_left[n_jobs]    = burst;
                rep.status   = rrss_pkg::STAT_LOADED;
                rep.job_slot = n_jobs[rrss_pkg::SLOT_OUT_W-1:0];
                n_jobs++;
            end
        end else if (req.cmd == rrss_pkg::CMD_CLEAR) begin
            // The quantum survives a clear; everything else starts again.
            n_jobs      = 0;
            n_done      = 0;
            clock_value = 0;
            last_served = 0;
            dispatching = 1'b0;
            wait_total  = 0;
            turn_total  = 0;
            rep.status  = rrss_pkg::STAT_CLEARED;
        end else begin
            sel = -1;
            // Cyclic scan after the job served last, which is itself the
            // final candidate, so a lone remaining job keeps running.
            if (dispatching) begin
                for (int i = 1; i <= n_jobs; i++) begin
                    slot = (last_served + i) % n_jobs;
                    if (sel < 0 && job_left[slot] != 0 && job_arrival[slot] <= clock_value) begin
                        sel = slot;
                    end
                end
            end
            // Otherwise the earliest arrival wins, lowest slot on ties.
            if (sel < 0) begin
                for (int i = 0; i < n_jobs; i++) begin
                    if (job_left[i] != 0 && (sel < 0 || job_arrival[i] < job_arrival[sel])) begin
                        sel = i;
                    end
                end
            end
            if (sel < 0) begin
                rep.status = rrss_pkg::STAT_NONE;
                empty_dispatches++;
            end else begin
                step = (quantum_setting == 0) ? 1 : quantum_setting;
                run  = (job_left[sel] < step) ? job_left[sel] : step;
                // With nothing arrived yet the clock jumps forward first.
                if (clock_value < job_arrival[sel]) begin
                    clock_value = 32'(job_arrival[sel]);
                    idle_jumps++;
                end
                clock_value = clock_value + run;
                if (clock_value > NOW_CEILING) begin
                    clock_value = NOW_CEILING;
                end
                job_left[sel] = rrss_pkg::ARR_W'(job_left[sel] - run);
                last_served = sel;
                dispatching = 1'b1;
                slices_run++;
                rep.status       = rrss_pkg::STAT_SLICE;
                rep.job_slot     = sel[rrss_pkg::SLOT_OUT_W-1:0];
                rep.slice_length = run[rrss_pkg::ARR_W-1:0];
                if (job_left[sel] == 0) begin
                    turn = clock_value - job_arrival[sel];
                    queued_for = (turn > job_burst[sel]) ? turn - job_burst[sel] : 0;
                    n_done++;
                    jobs_completed++;
                    wait_total = wait_total + queued_for;
                    if (wait_total > TOTAL_CEILING) begin
                        wait_total = TOTAL_CEILING;
                    end
                    turn_total = turn_total + turn;
                    if (turn_total > TOTAL_CEILING) begin
                        turn_total = TOTAL_CEILING;
                    end
                    rep.job_finished    = 1'b1;
                    rep.waiting_time    = queued_for[rrss_pkg::TIME_W-1:0];
                    rep.turnaround_time = turn[rrss_pkg::TIME_W-1:0];
                end
            end
        end
        rep.finish_time    = clock_value[rrss_pkg::TIME_W-1:0];
        rep.sum_waiting    = wait_total[rrss_pkg::TOTAL_W-1:0];
        rep.sum_turnaround = turn_total[rrss_pkg::TOTAL_W-1:0];
        rep.all_done       = (n_done == n_jobs);
        report_queue = {report_queue, rep};
    endtask

    // ------------------------------------------------------------------------
    // Request driver. A new request is put on the bus only when the bus is
    // free, so tvalid gets exactly one assignment per clock edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic fire;
        logic next_valid;
        fire       = i_s_axis_tvalid && o_s_axis_tready;
        next_valid = i_s_axis_tvalid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (fire) begin
                schedule_request(offered_request);
                accepted_requests++;
                // Switch now and then between idling and back-to-back mode.
                if ($urandom_range(0, 39) == 0) begin
                    send_quiet = !send_quiet;
                end
            end
            if (!i_s_axis_tvalid || fire) begin
                if (send_gap > 0) begin
                    send_gap--;
                    next_valid = 1'b0;
                end else if (request_queue.size() > 0) begin
                    offered_request = request_queue.pop_front();
                    next_valid      = 1'b1;
                    i_s_axis_tdata  <= {offered_request.burst, offered_request.arrival};
                    i_s_axis_tuser  <= offered_request.cmd;
                    send_gap        = send_quiet ? 0 : idle_length();
                end else begin
                    next_valid = 1'b0;
                end
            end
        end
        i_s_axis_tvalid <= next_valid;
    end

    // Compares one report field and logs a mismatch.
    task automatic check_field(input string label, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            fail_count++;
            if (fail_count <= PRINT_LIMIT) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Report monitor. It also decides the ready of the report side,
    // including the one long hold-off that backs the block up.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        rrss_pkg::t_result seen;
        rrss_pkg::t_result want;
        logic              next_ready;
        next_ready = i_m_axis_tready;
        if (!i_rst_n) begin
            next_ready = 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                seen.status          = rrss_pkg::t_status'(o_m_axis_tuser);
                seen.job_slot        = o_m_axis_tdata[3:0];
                seen.slice_length    = o_m_axis_tdata[19:4];
                seen.finish_time     = o_m_axis_tdata[40:20];
                seen.job_finished    = o_m_axis_tdata[41];
                seen.waiting_time    = o_m_axis_tdata[62:42];
                seen.turnaround_time = o_m_axis_tdata[83:63];
                seen.sum_waiting     = o_m_axis_tdata[108:84];
                seen.sum_turnaround  = o_m_axis_tdata[133:109];
                seen.all_done        = o_m_axis_tdata[134];
                reports_checked++;
                if (report_queue.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected report: expected none, actual status %0d",
                             $time, seen.status);
                end else begin
                    want = report_queue.pop_front();
                    check_field("status", 32'(want.status), 32'(seen.status));
                    check_field("job_slot", 32'(want.job_slot), 32'(seen.job_slot));
                    check_field("slice_length", 32'(want.slice_length),
                                32'(seen.slice_length));
                    check_field("finish_time", 32'(want.finish_time),
                                32'(seen.finish_time));
                    check_field("job_finished", 32'(want.job_finished),
                                32'(seen.job_finished));
                    check_field("waiting_time", 32'(want.waiting_time),
                                32'(seen.waiting_time));
                    check_field("turnaround_time", 32'(want.turnaround_time),
                                32'(seen.turnaround_time));
                    check_field("sum_waiting", 32'(want.sum_waiting),
                                32'(seen.sum_waiting));
                    check_field("sum_turnaround", 32'(want.sum_turnaround),
                                32'(seen.sum_turnaround));
                    check_field("all_done", 32'(want.all_done), 32'(seen.all_done));
                    check_field("padding", 0, 32'(o_m_axis_tdata[135]));
                end
            end
            if (long_hold_wanted && !long_hold_taken) begin
                long_hold_taken = 1'b1;
                recv_hold       = LONG_HOLD;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
                if (!recv_quiet && $urandom_range(0, 99) < 30) begin
                    recv_hold = idle_length();
                end
            end
            if ($urandom_range(0, 63) == 0) begin
                recv_quiet = !recv_quiet;
            end
        end
        i_m_axis_tready <= next_ready;
    end

    // ------------------------------------------------------------------------
    // Watchdog: any handshake on any channel counts as progress.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d reports still expected",
                     $time, quiet_cycles, report_queue.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic add_request(input logic [rrss_pkg::CMD_W-1:0] cmd,
                               input logic [rrss_pkg::ARR_W-1:0] arrival,
                               input logic [rrss_pkg::ARR_W-1:0] burst);
        t_request req;
        req = '{cmd: cmd, arrival: arrival, burst: burst};
        request_queue = {request_queue, req};
        if (cmd != CMD_UNUSED) begin
            planned_requests++;
        end
    endtask

    // Waits until every request is taken and every report has come, then
    // lets the longest dispatch time pass in case an unused command is
    // still being worked on.
    task automatic drain_reports();
        do begin
            @(negedge i_clk);
        end while (request_queue.size() != 0 || i_s_axis_tvalid || report_queue.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the slice quantum over the configuration channel.
    task automatic write_quantum(input logic [rrss_pkg::QUANTUM_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        quantum_setting = 32'(value);
        quantum_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // Plans one job load and, if the table has room, adds its expected number of slices.
    task automatic plan_load(input int unsigned span, inout int unsigned held,
                             inout int unsigned slices);
        int unsigned roll;
        int unsigned cap;
        logic [rrss_pkg::ARR_W-1:0] arrival;
        logic [rrss_pkg::ARR_W-1:0] burst;
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            arrival = rrss_pkg::ARR_W'($urandom_range(0, 40));
        end else if (roll < 80) begin
            arrival = rrss_pkg::ARR_W'($urandom_range(0, 400));
        end else begin
            arrival = rrss_pkg::ARR_W'($urandom_range(0, 65535));
        end
        // Bursts stay within a handful of slices of the current quantum.
        cap  = (span * 6 > 65535) ? 65535 : span * 6;
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
            burst = '0;
        end else if (roll < 10) begin
            burst = rrss_pkg::ARR_W'(cap);
        end else begin
            burst = rrss_pkg::ARR_W'($urandom_range(1, cap));
        end
        add_request(rrss_pkg::CMD_LOAD, arrival, burst);
        if (held < JOB_SLOTS) begin
            held++;
            slices += (burst == 0) ? 1 : (burst + span - 1) / span;
        end
    endtask

    // Plans one set of jobs: usually a clear, a batch of loads and enough
    // dispatches to finish them, with some noise, late loads and an
    // occasional clear in the middle of the run.
    task automatic plan_job_set(input int unsigned q, input bit fill_table);
        int unsigned span;
        int unsigned loads;
        int unsigned slices;
        int unsigned held;
        int unsigned roll;
        span   = (q == 0) ? 1 : q;
        held   = 0;
        slices = 0;
        if (fill_table || $urandom_range(0, 9) != 0) begin
            add_request(rrss_pkg::CMD_CLEAR, any_field(), any_field());
        end
        roll = $urandom_range(0, 99);
        if (fill_table) begin
            loads = JOB_SLOTS + 1;
        end else if (roll < 75) begin
            loads = $urandom_range(1, 6);
        end else if (roll < 93) begin
            loads = $urandom_range(7, JOB_SLOTS);
        end else begin
            loads = $urandom_range(JOB_SLOTS + 1, JOB_SLOTS + 3);
        end
        repeat (loads) plan_load(span, held, slices);
        slices += $urandom_range(0, 2);
        while (slices > 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                add_request(CMD_UNUSED, any_field(), any_field());
            end else if (roll < 9) begin
                plan_load(span, held, slices);
            end else if (roll < 10) begin
                add_request(rrss_pkg::CMD_CLEAR, any_field(), any_field());
                slices = 0;
            end else begin
                add_request(rrss_pkg::CMD_DISPATCH, any_field(), any_field());
                slices--;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned phase_quanta [4];
        int unsigned phase_target;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset quantum of ten: empty table, unused
        // command, a zero burst, a tie on arrival, the lone remaining job,
        // an idle clock jump to a late arrival, and a clear.
        add_request(rrss_pkg::CMD_DISPATCH, any_field(), any_field());
        add_request(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
        add_request(rrss_pkg::CMD_LOAD, 16'd100, 16'd0);
        add_request(rrss_pkg::CMD_LOAD, 16'd5, 16'd25);
        add_request(rrss_pkg::CMD_LOAD, 16'd5, 16'd3);
        repeat (7) add_request(rrss_pkg::CMD_DISPATCH, any_field(), any_field());
        add_request(rrss_pkg::CMD_CLEAR, any_field(), any_field());
        add_request(rrss_pkg::CMD_DISPATCH, any_field(), any_field());
        drain_reports();

        // A zero quantum behaves as one.
        write_quantum(16'd0);
        add_request(rrss_pkg::CMD_LOAD, 16'd0, 16'd3);
        repeat (4) add_request(rrss_pkg::CMD_DISPATCH, any_field(), any_field());
        add_request(rrss_pkg::CMD_CLEAR, any_field(), any_field());
        drain_reports();

        // Largest quantum with the extremes of arrival and burst.
        write_quantum(16'hFFFF);
        add_request(rrss_pkg::CMD_LOAD, 16'hFFFF, 16'hFFFF);
        add_request(rrss_pkg::CMD_LOAD, 16'd0, 16'hFFFF);
        repeat (3) add_request(rrss_pkg::CMD_DISPATCH, any_field(), any_field());
        drain_reports();

        // Random phases: smallest quantum, a small one, the largest and a
        // medium one. The sender pauses at the end of each phase until every
        // report has come back.
        phase_quanta[0] = 1;
        phase_quanta[1] = $urandom_range(2, 40);
        phase_quanta[2] = 65535;
        phase_quanta[3] = $urandom_range(41, 3000);
        for (int p = 0; p < 4; p++) begin
            write_quantum(rrss_pkg::QUANTUM_W'(phase_quanta[p]));
            phase_target = planned_requests + PHASE_REQUESTS;
            plan_job_set(phase_quanta[p], (p == 0 || p == 2));
            while (planned_requests < phase_target) begin
                plan_job_set(phase_quanta[p], 1'b0);
            end
            // One long hold-off of the report side while requests keep
            // coming, so the block fills up and stops taking requests.
            if (p == 1) begin
                long_hold_wanted = 1'b1;
            end
            drain_reports();
        end

        $display("Run summary: %0d requests under %0d quantum writes, %0d reports checked.",
                 accepted_requests, quantum_writes, reports_checked);
        $display("Run summary: %0d slices, %0d jobs done, %0d full, %0d idle jumps, %0d empty.",
                 slices_run, jobs_completed, full_rejects, idle_jumps, empty_dispatches);
        if (fail_count == 0 && report_queue.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
